FILE: sv/hsv2rgb_pkg.sv
`default_nettype none
package hsv2rgb_pkg;

    localparam int unsigned HUE_W  = 16;
    localparam int unsigned PCT_W  = 7;
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned HMOD_W = 9;
    localparam int unsigned OFS_W  = 6;

    localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
    localparam logic [CHAN_W-1:0] CHAN_FULL  = 8'd255;
    localparam logic [HMOD_W-1:0] HUE_TURN   = 9'd360;
    localparam logic [HMOD_W-1:0] HUE_SECTOR = 9'd60;

    // floor(x/360) from below for 16-bit x: (x*2912)>>20 is q or q-1
    localparam logic [11:0] RECIP_360 = 12'd2912;
    localparam int unsigned RECIP_360_SH = 20;
    // floor(x/100) for x <= 25500: (x*5243)>>19, exact
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int unsigned RECIP_100_SH = 19;
    // floor(x/60) for x <= 15045: (x*17477)>>20, exact
    localparam logic [14:0] RECIP_60 = 15'd17477;
    localparam int unsigned RECIP_60_SH = 20;

    // sextant of the hue circle: which channel is max and which one ramps
    typedef enum logic [2:0] {
        SEC_RED_GRN_UP = 3'd0,
        SEC_GRN_RED_DN = 3'd1,
        SEC_GRN_BLU_UP = 3'd2,
        SEC_BLU_GRN_DN = 3'd3,
        SEC_BLU_RED_UP = 3'd4,
        SEC_RED_BLU_DN = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t           sector;
        logic [OFS_W-1:0]  offset;
        logic [CHAN_W-1:0] top;
        logic [PCT_W-1:0]  sat;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage
`default_nettype wire

FILE: sv/hsv2rgb_front.sv
`default_nettype none
module hsv2rgb_front
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [hsv2rgb_pkg::HUE_W-1:0]    hue,
    input  wire logic [hsv2rgb_pkg::PCT_W-1:0]    saturation,
    input  wire logic [hsv2rgb_pkg::PCT_W-1:0]    brightness,
    input  wire hsv2rgb_pkg::queue_stat_t         stat,
    output logic                                  busy,
    output logic                                  push,
    output hsv2rgb_pkg::work_t                    push_data
);

    logic                              en;
    logic                              accept;
    logic [hsv2rgb_pkg::PCT_W-1:0]     sat_c;
    logic [hsv2rgb_pkg::PCT_W-1:0]     val_c;
    logic [27:0]                       hprod;
    logic [16:0]                       rem_wide;
    logic [9:0]                        rem;
    logic [hsv2rgb_pkg::HMOD_W-1:0]    hmod_next;
    logic [27:0]                       tprod;
    logic [hsv2rgb_pkg::HMOD_W-1:0]    ofs_wide;

    logic                              v1_reg;
    logic [hsv2rgb_pkg::HUE_W-1:0]     hue1_reg;
    logic [7:0]                        hq1_reg;
    logic [14:0]                       vm1_reg;
    logic [hsv2rgb_pkg::PCT_W-1:0]     sat1_reg;

    logic                              v2_reg;
    logic [hsv2rgb_pkg::HMOD_W-1:0]    hmod2_reg;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    top2_reg;
    logic [hsv2rgb_pkg::PCT_W-1:0]     sat2_reg;

    assign en     = !stat.full;
    assign busy   = stat.full;
    assign accept = start && !busy;

    assign sat_c = (saturation > hsv2rgb_pkg::PCT_FULL) ? hsv2rgb_pkg::PCT_FULL : saturation;
    assign val_c = (brightness > hsv2rgb_pkg::PCT_FULL) ? hsv2rgb_pkg::PCT_FULL : brightness;
    assign hprod = 28'(hue) * 28'(hsv2rgb_pkg::RECIP_360);

    // quotient estimate may be one short: one correction step
    assign rem_wide = 17'(hue1_reg) - (17'(hq1_reg) * 17'(hsv2rgb_pkg::HUE_TURN));
    assign rem      = rem_wide[9:0];
    assign hmod_next = (rem >= 10'(hsv2rgb_pkg::HUE_TURN))
                     ? 9'(rem - 10'(hsv2rgb_pkg::HUE_TURN)) : rem[8:0];
    assign tprod = 28'(vm1_reg) * 28'(hsv2rgb_pkg::RECIP_100);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue1_reg  <= hue;
            hq1_reg   <= hprod[27:hsv2rgb_pkg::RECIP_360_SH];
            vm1_reg   <= 15'(val_c) * 15'(hsv2rgb_pkg::CHAN_FULL);
            sat1_reg  <= sat_c;
            hmod2_reg <= hmod_next;
            top2_reg  <= tprod[hsv2rgb_pkg::RECIP_100_SH +: 8];
            sat2_reg  <= sat1_reg;
        end
    end

    // classify the reduced hue into sextant and offset
    always_comb
    begin
        if (hmod2_reg >= 5 * hsv2rgb_pkg::HUE_SECTOR)
        begin
            push_data.sector = hsv2rgb_pkg::SEC_RED_BLU_DN;
            ofs_wide = hmod2_reg - 9'(5 * hsv2rgb_pkg::HUE_SECTOR);
        end
        else if (hmod2_reg >= 4 * hsv2rgb_pkg::HUE_SECTOR)
        begin
            push_data.sector = hsv2rgb_pkg::SEC_BLU_RED_UP;
            ofs_wide = hmod2_reg - 9'(4 * hsv2rgb_pkg::HUE_SECTOR);
        end
        else if (hmod2_reg >= 3 * hsv2rgb_pkg::HUE_SECTOR)
        begin
            push_data.sector = hsv2rgb_pkg::SEC_BLU_GRN_DN;
            ofs_wide = hmod2_reg - 9'(3 * hsv2rgb_pkg::HUE_SECTOR);
        end
        else if (hmod2_reg >= 2 * hsv2rgb_pkg::HUE_SECTOR)
        begin
            push_data.sector = hsv2rgb_pkg::SEC_GRN_BLU_UP;
            ofs_wide = hmod2_reg - 9'(2 * hsv2rgb_pkg::HUE_SECTOR);
        end
        else if (hmod2_reg >= hsv2rgb_pkg::HUE_SECTOR)
        begin
            push_data.sector = hsv2rgb_pkg::SEC_GRN_RED_DN;
            ofs_wide = hmod2_reg - hsv2rgb_pkg::HUE_SECTOR;
        end
        else
        begin
            push_data.sector = hsv2rgb_pkg::SEC_RED_GRN_UP;
            ofs_wide = hmod2_reg;
        end
        push_data.offset = ofs_wide[hsv2rgb_pkg::OFS_W-1:0];
        push_data.top    = top2_reg;
        push_data.sat    = sat2_reg;
    end

    assign push = v2_reg && en;

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> v1_reg)
        else $error("accepted request did not enter front stage");

    a_hmod_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (hmod2_reg < hsv2rgb_pkg::HUE_TURN))
        else $error("hue reduction out of range");

endmodule
`default_nettype wire

FILE: sv/hsv2rgb_queue.sv
`default_nettype none
module hsv2rgb_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire hsv2rgb_pkg::work_t       push_data,
    input  wire logic                     pop,
    output hsv2rgb_pkg::work_t            head,
    output hsv2rgb_pkg::queue_stat_t      stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    hsv2rgb_pkg::work_t   mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;

    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!push && pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: sv/hsv2rgb_back.sv
`default_nettype none
module hsv2rgb_back
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire hsv2rgb_pkg::queue_stat_t         stat,
    input  wire hsv2rgb_pkg::work_t               head,
    output logic                                  pop,
    output logic                                  done,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]        red,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]        green,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]        blue
);

    logic                              b1_v_reg;
    hsv2rgb_pkg::sector_t              b1_sec_reg;
    logic [hsv2rgb_pkg::OFS_W-1:0]     b1_ofs_reg;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    b1_top_reg;
    logic [14:0]                       b1_bprod_reg;

    logic                              b2_v_reg;
    hsv2rgb_pkg::sector_t              b2_sec_reg;
    logic [hsv2rgb_pkg::OFS_W-1:0]     b2_ofs_reg;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    b2_top_reg;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    b2_bot_reg;

    logic                              b3_v_reg;
    hsv2rgb_pkg::sector_t              b3_sec_reg;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    b3_top_reg;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    b3_bot_reg;
    logic [13:0]                       b3_rprod_reg;

    logic                              b4_v_reg;
    hsv2rgb_pkg::sector_t              b4_sec_reg;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    b4_top_reg;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    b4_bot_reg;
    logic [28:0]                       b4_rq_reg;

    logic                              done_reg;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    red_reg;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    green_reg;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    blue_reg;

    logic [27:0]                       bq;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    ramp;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    rise;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    fall;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    red_next;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    green_next;
    logic [hsv2rgb_pkg::CHAN_W-1:0]    blue_next;

    assign pop = !stat.empty;

    assign bq   = 28'(b1_bprod_reg) * 28'(hsv2rgb_pkg::RECIP_100);
    assign ramp = b4_rq_reg[hsv2rgb_pkg::RECIP_60_SH +: 8];
    assign rise = b4_bot_reg + ramp;
    assign fall = b4_top_reg - ramp;

    always_comb
    begin
        case (b4_sec_reg)
            hsv2rgb_pkg::SEC_RED_GRN_UP:
            begin
                red_next = b4_top_reg; green_next = rise;       blue_next = b4_bot_reg;
            end
            hsv2rgb_pkg::SEC_GRN_RED_DN:
            begin
                red_next = fall;       green_next = b4_top_reg; blue_next = b4_bot_reg;
            end
            hsv2rgb_pkg::SEC_GRN_BLU_UP:
            begin
                red_next = b4_bot_reg; green_next = b4_top_reg; blue_next = rise;
            end
            hsv2rgb_pkg::SEC_BLU_GRN_DN:
            begin
                red_next = b4_bot_reg; green_next = fall;       blue_next = b4_top_reg;
            end
            hsv2rgb_pkg::SEC_BLU_RED_UP:
            begin
                red_next = rise;       green_next = b4_bot_reg; blue_next = b4_top_reg;
            end
            default:
            begin
                red_next = b4_top_reg; green_next = b4_bot_reg; blue_next = fall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
            b3_v_reg <= 1'b0;
            b4_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            b1_v_reg <= pop;
            b2_v_reg <= b1_v_reg;
            b3_v_reg <= b2_v_reg;
            b4_v_reg <= b3_v_reg;
            done_reg <= b4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_sec_reg   <= head.sector;
        b1_ofs_reg   <= head.offset;
        b1_top_reg   <= head.top;
        b1_bprod_reg <= 15'(head.top) * 15'(hsv2rgb_pkg::PCT_FULL - head.sat);

        b2_sec_reg <= b1_sec_reg;
        b2_ofs_reg <= b1_ofs_reg;
        b2_top_reg <= b1_top_reg;
        b2_bot_reg <= bq[hsv2rgb_pkg::RECIP_100_SH +: 8];

        b3_sec_reg   <= b2_sec_reg;
        b3_top_reg   <= b2_top_reg;
        b3_bot_reg   <= b2_bot_reg;
        b3_rprod_reg <= 14'(b2_top_reg - b2_bot_reg) * 14'(b2_ofs_reg);

        b4_sec_reg <= b3_sec_reg;
        b4_top_reg <= b3_top_reg;
        b4_bot_reg <= b3_bot_reg;
        b4_rq_reg  <= 29'(b3_rprod_reg) * 29'(hsv2rgb_pkg::RECIP_60);

        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    a_bot_le_top: assert property (@(posedge clk) disable iff (!rst_n)
        b3_v_reg |-> (b3_bot_reg <= b3_top_reg))
        else $error("minimum above maximum");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(b1_v_reg) |-> ##4 done)
        else $error("result strobe missing");

endmodule
`default_nettype wire

FILE: sv/hsv_to_rgb_converter.sv
// HSV to RGB: one request per clock while busy is low; result strobed on done.
// Stages: 2 front stages, 1 queue write, 4 back stages and the output registers.
// Throughput: one request per cycle; the result side cannot stall, so the queue
// stays near empty and busy only rises if the queue ever fills.
// Reset (rst_n, async low) clears all valid flags and the queue pointers.
`default_nettype none
module hsv_to_rgb_converter
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [hsv2rgb_pkg::HUE_W-1:0]    hue,
    input  wire logic [hsv2rgb_pkg::PCT_W-1:0]    saturation,
    input  wire logic [hsv2rgb_pkg::PCT_W-1:0]    brightness,
    output logic                                  done,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]        red,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]        green,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]        blue
);

    hsv2rgb_pkg::queue_stat_t  stat;
    hsv2rgb_pkg::work_t        push_data;
    hsv2rgb_pkg::work_t        head;
    logic                      push;
    logic                      pop;

    hsv2rgb_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .stat       (stat),
        .busy       (busy),
        .push       (push),
        .push_data  (push_data)
    );

    hsv2rgb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head       (head),
        .stat       (stat)
    );

    hsv2rgb_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .stat       (stat),
        .head       (head),
        .pop        (pop),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int unsigned HUE_W  = hsv2rgb_pkg::HUE_W;
    localparam int unsigned PCT_W  = hsv2rgb_pkg::PCT_W;
    localparam int unsigned CHAN_W = hsv2rgb_pkg::CHAN_W;

    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned PIPE_LATENCY = 8;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct {
        logic [HUE_W-1:0]  hue;
        logic [PCT_W-1:0]  sat;
        logic [PCT_W-1:0]  val;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [HUE_W-1:0]  hue;
    logic [PCT_W-1:0]  saturation;
    logic [PCT_W-1:0]  brightness;
    logic              done;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    pixel_t      pending_pixels[$];
    int unsigned idle_pct;
    int unsigned colors_sent;
    int unsigned colors_checked;
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned sector_hits[6];

    hsv_to_rgb_converter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // expected RGB for one HSV request
    function automatic pixel_t hsv_color(input logic [HUE_W-1:0] h,
                                         input logic [PCT_W-1:0] s_in,
                                         input logic [PCT_W-1:0] v_in);
        int unsigned          deg;
        int unsigned          s;
        int unsigned          v;
        int unsigned          top;
        int unsigned          bot;
        int unsigned          ramp;
        int unsigned          rise;
        int unsigned          fall;
        hsv2rgb_pkg::sector_t sec;
        pixel_t               p;
        deg  = h % 360;
        s    = (s_in > 100) ? 100 : s_in;
        v    = (v_in > 100) ? 100 : v_in;
        top  = (v * 255) / 100;
        bot  = (top * (100 - s)) / 100;
        ramp = ((top - bot) * (deg % 60)) / 60;
        rise = bot + ramp;
        fall = top - ramp;
        sec  = hsv2rgb_pkg::sector_t'(deg / 60);
        p.hue = h;
        p.sat = s_in;
        p.val = v_in;
        case (sec)
            hsv2rgb_pkg::SEC_RED_GRN_UP:
            begin
                p.red = top[7:0];  p.green = rise[7:0]; p.blue = bot[7:0];
            end
            hsv2rgb_pkg::SEC_GRN_RED_DN:
            begin
                p.red = fall[7:0]; p.green = top[7:0];  p.blue = bot[7:0];
            end
            hsv2rgb_pkg::SEC_GRN_BLU_UP:
            begin
                p.red = bot[7:0];  p.green = top[7:0];  p.blue = rise[7:0];
            end
            hsv2rgb_pkg::SEC_BLU_GRN_DN:
            begin
                p.red = bot[7:0];  p.green = fall[7:0]; p.blue = top[7:0];
            end
            hsv2rgb_pkg::SEC_BLU_RED_UP:
            begin
                p.red = rise[7:0]; p.green = bot[7:0];  p.blue = top[7:0];
            end
            default:
            begin
                p.red = top[7:0];  p.green = bot[7:0];  p.blue = fall[7:0];
            end
        endcase
        return p;
    endfunction

    // one request; start stays high afterwards so back-to-back requests need no gap
    task automatic send_color(input logic [HUE_W-1:0] h,
                              input logic [PCT_W-1:0] s,
                              input logic [PCT_W-1:0] v);
        @(negedge clk);
        start      <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        do
            @(posedge clk);
        while (busy);
        pending_pixels.push_back(hsv_color(h, s, v));
        sector_hits[(h % 360) / 60]++;
        colors_sent++;
    endtask

    task automatic idle_sender();
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_edge_cases();
        idle_pct = 0;
        // every sextant mid-point, at full, half, 75 and 25 percent saturation
        send_color(16'd30,  7'd100, 7'd100);
        send_color(16'd90,  7'd100, 7'd100);
        send_color(16'd150, 7'd50,  7'd100);
        send_color(16'd210, 7'd50,  7'd80);
        send_color(16'd270, 7'd75,  7'd60);
        send_color(16'd330, 7'd25,  7'd100);
        // sextant boundaries and hue wrap
        send_color(16'd0,     7'd100, 7'd100);
        send_color(16'd59,    7'd100, 7'd100);
        send_color(16'd60,    7'd100, 7'd100);
        send_color(16'd359,   7'd100, 7'd100);
        send_color(16'd360,   7'd100, 7'd100);
        send_color(16'd719,   7'd100, 7'd100);
        send_color(16'd65535, 7'd100, 7'd100);
        send_color(16'd65520, 7'd60,  7'd90);
        // grey, black, clamps
        send_color(16'd123,   7'd0,   7'd100);
        send_color(16'd200,   7'd0,   7'd37);
        send_color(16'd45,    7'd100, 7'd0);
        send_color(16'd45,    7'd127, 7'd127);
        send_color(16'd300,   7'd101, 7'd101);
        send_color(16'd100,   7'd127, 7'd50);
        send_color(16'd250,   7'd50,  7'd127);
        send_color(16'd0,     7'd0,   7'd0);
        wait_drained();
    endtask

    task automatic test_random_colors(input int unsigned count, input int unsigned pct);
        logic [HUE_W-1:0] h;
        logic [PCT_W-1:0] s;
        logic [PCT_W-1:0] v;
        idle_pct = pct;
        repeat (count)
        begin
            h = ($urandom_range(99) < 60) ? HUE_W'($urandom_range(359)) : HUE_W'($urandom);
            s = ($urandom_range(99) < 80) ? PCT_W'($urandom_range(100))
                                         : PCT_W'($urandom_range(127));
            v = ($urandom_range(99) < 80) ? PCT_W'($urandom_range(100))
                                         : PCT_W'($urandom_range(127));
            send_color(h, s, v);
            idle_sender();
        end
    endtask

    // sender holds off until the pipeline is empty, then bursts again
    task automatic test_drain_pause();
        test_random_colors(40, 0);
        wait_drained();
        test_random_colors(40, 10);
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        pixel_t exp_px;
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result rgb=%0d/%0d/%0d", red, green, blue);
            end
            else
            begin
                exp_px = pending_pixels.pop_front();
                colors_checked++;
                if (red !== exp_px.red || green !== exp_px.green || blue !== exp_px.blue)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("mismatch h=%0d s=%0d v=%0d: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 exp_px.hue, exp_px.sat, exp_px.val,
                                 exp_px.red, exp_px.green, exp_px.blue, red, green, blue);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_pixels.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        start          = 1'b0;
        hue            = '0;
        saturation     = '0;
        brightness     = '0;
        rst_n          = 1'b0;
        idle_pct       = 0;
        colors_sent    = 0;
        colors_checked = 0;
        error_count    = 0;
        cycle_count    = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_edge_cases();
        test_random_colors(460, 25);
        test_drain_pause();
        test_random_colors(450, 63);
        test_random_colors(410, 0);

        wait_drained();
        repeat (PIPE_LATENCY + 10) @(posedge clk);
        if (pending_pixels.size() != 0)
        begin
            error_count++;
            $display("%0d results never arrived", pending_pixels.size());
        end

        $display("Converted %0d colors (%0d checked) with sender gaps of 0, 25 and 63 percent.",
                 colors_sent, colors_checked);
        $display("Per-sextant hits: %0d %0d %0d %0d %0d %0d; hue wrap and s/v clamps included.",
                 sector_hits[0], sector_hits[1], sector_hits[2],
                 sector_hits[3], sector_hits[4], sector_hits[5]);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
sv/hsv2rgb_pkg.sv
sv/hsv2rgb_front.sv
sv/hsv2rgb_queue.sv
sv/hsv2rgb_back.sv
sv/hsv_to_rgb_converter.sv
verif/tb.sv
